// ===== rtl/tcc_pkg.sv =====
// Package for the thermal code converter: transfer payload types, operation and
// status codes, and the two-level PMIC sensor lookup tables.
// No dependencies.
package tcc_pkg;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;

  localparam op_t OP_LIN_ENC = 2'd0;
  localparam op_t OP_LIN_DEC = 2'd1;
  localparam op_t OP_TAB_ENC = 2'd2;
  localparam op_t OP_TAB_DEC = 2'd3;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_RANGE  = 2'd1;
  localparam status_t ST_SENSOR = 2'd2;

  typedef struct packed {
    op_t                operation;
    logic               sensor_is_pmic;
    logic signed [15:0] value;
  } tcc_in_t;

  typedef struct packed {
    logic signed [15:0] result_value;
    status_t            status;
  } tcc_out_t;

  localparam logic signed [15:0] LIN_T_MIN = -16'sd40;
  localparam logic signed [15:0] LIN_T_MAX = 16'sd120;
  localparam logic signed [15:0] LIN_C_MIN = 16'sd623;

  // Linear encode: (t + 40) * 407 / 160 computed as d * LIN_ENC_MUL >> 16.
  localparam logic [17:0] LIN_ENC_MUL = 18'd166708;
  // Linear decode: |code - 623| * 160 / 407 computed as m * LIN_DEC_MUL >> 25.
  localparam logic [23:0] LIN_DEC_MUL = 24'd13190932;

  localparam logic [2:0] COARSE_MASK = 3'h7;
  localparam logic [3:0] FINE_MASK   = 4'hF;

  function automatic logic signed [15:0] coarse_temp(input logic [2:0] idx);
    logic signed [15:0] t;
    case (idx)
      3'd0:    t = -16'sd56;
      3'd1:    t = -16'sd29;
      3'd2:    t = -16'sd2;
      3'd3:    t = 16'sd26;
      3'd4:    t = 16'sd53;
      3'd5:    t = 16'sd79;
      3'd6:    t = 16'sd106;
      3'd7:    t = 16'sd133;
      default: t = 16'sd0;
    endcase
    return t;
  endfunction

  function automatic logic signed [15:0] fine_temp(input logic [3:0] idx);
    logic signed [15:0] t;
    case (idx)
      4'd0:    t = 16'sd0;
      4'd1:    t = 16'sd2;
      4'd2:    t = 16'sd3;
      4'd3:    t = 16'sd5;
      4'd4:    t = 16'sd7;
      4'd5:    t = 16'sd8;
      4'd6:    t = 16'sd10;
      4'd7:    t = 16'sd11;
      4'd8:    t = 16'sd13;
      4'd9:    t = 16'sd15;
      4'd10:   t = 16'sd17;
      4'd11:   t = 16'sd18;
      4'd12:   t = 16'sd20;
      4'd13:   t = 16'sd21;
      4'd14:   t = 16'sd23;
      4'd15:   t = 16'sd25;
      default: t = 16'sd0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/thermal_code_converter.sv =====
// Top level of the thermal code converter: input register, conversion core and
// result register. Depends on tcc_pkg and tcc_convert.
//
// Usage:
// The input channel (in_valid, in_ready, in_data) carries an operation, a sensor
// select and a 16-bit value. The result channel (out_valid, out_ready, out_data)
// returns one converted value and a status for every input transfer, in order.
// An input transfer is registered in the input register, converted by combinational
// logic and stored in the result register; out_valid rises when the result is
// loaded there, and the result transfers from the result register.
// With out_ready high the two-stage register pipeline takes one item per cycle.
// When the receiver stalls, the result register holds its transfer, and the
// input register can still take one more item; in_ready then drops until
// out_ready returns. Reset (rst_n low at a clock edge) empties both stages.
// There are no configuration registers and no state between items.
module thermal_code_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcc_pkg::tcc_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tcc_pkg::tcc_out_t  out_data
);

  tcc_pkg::tcc_in_t  in_r;
  logic              in_valid_r;
  logic              in_valid_nxt;
  tcc_pkg::tcc_out_t out_r;
  tcc_pkg::tcc_out_t out_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              adv;

  tcc_convert u_convert (
    .item (in_r),
    .res  (out_nxt)
  );

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || adv;

  assign in_valid_nxt  = in_ready ? in_valid : in_valid_r;
  assign out_valid_nxt = adv ? in_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (adv && in_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/tcc_convert.sv =====
// Combinational conversion core of the thermal code converter.
// Depends on tcc_pkg for payload types, codes and the lookup tables.
module tcc_convert (
  input  tcc_pkg::tcc_in_t  item,
  output tcc_pkg::tcc_out_t res
);

  logic signed [15:0] v;
  logic               enc_bad;
  logic [15:0]        enc_d;
  logic [25:0]        enc_prod;
  logic signed [15:0] enc_val;

  logic signed [15:0] dec_diff;
  logic               dec_neg;
  logic [15:0]        dec_abs;
  logic [38:0]        dec_prod;
  logic signed [15:0] dec_q;
  logic signed [15:0] dec_val;

  logic [2:0]         hi;
  logic [3:0]         lo;
  logic signed [15:0] rem;
  logic signed [15:0] tenc_val;
  logic signed [15:0] tdec_val;

  assign v = item.value;

  // Linear encode.
  assign enc_bad  = (v < tcc_pkg::LIN_T_MIN) || (v > tcc_pkg::LIN_T_MAX);
  assign enc_d    = v - tcc_pkg::LIN_T_MIN;
  assign enc_prod = enc_d[7:0] * tcc_pkg::LIN_ENC_MUL;
  assign enc_val  = tcc_pkg::LIN_C_MIN + $signed({6'd0, enc_prod[25:16]});

  // Linear decode, quotient truncated toward zero.
  assign dec_diff = $signed({1'b0, v[14:0]}) - tcc_pkg::LIN_C_MIN;
  assign dec_neg  = dec_diff[15];
  assign dec_abs  = dec_neg ? 16'(-dec_diff) : dec_diff;
  assign dec_prod = dec_abs[14:0] * tcc_pkg::LIN_DEC_MUL;
  assign dec_q    = $signed({2'd0, dec_prod[38:25]});
  assign dec_val  = dec_neg ? (tcc_pkg::LIN_T_MIN - dec_q) : (tcc_pkg::LIN_T_MIN + dec_q);

  // Table encode: coarse entry first, then fine entry on the remainder.
  always_comb begin
    hi = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (tcc_pkg::coarse_temp(3'(i)) <= v) begin
        hi = 3'(i);
      end
    end
  end

  assign rem = v - tcc_pkg::coarse_temp(hi);

  always_comb begin
    lo = 4'd0;
    for (int j = 0; j < 16; j++) begin
      if (tcc_pkg::fine_temp(4'(j)) <= rem) begin
        lo = 4'(j);
      end
    end
  end

  assign tenc_val = $signed({9'd0, hi, lo});

  // Table decode.
  assign tdec_val = tcc_pkg::coarse_temp(v[6:4] & tcc_pkg::COARSE_MASK)
                  + tcc_pkg::fine_temp(v[3:0] & tcc_pkg::FINE_MASK);

  always_comb begin
    res.result_value = 16'sd0;
    res.status       = tcc_pkg::ST_OK;
    case (item.operation)
      tcc_pkg::OP_LIN_ENC: begin
        if (enc_bad) begin
          res.status = tcc_pkg::ST_RANGE;
        end else begin
          res.result_value = enc_val;
        end
      end
      tcc_pkg::OP_LIN_DEC: begin
        res.result_value = dec_val;
      end
      tcc_pkg::OP_TAB_ENC: begin
        if (!item.sensor_is_pmic) begin
          res.status = tcc_pkg::ST_SENSOR;
        end else if (v < tcc_pkg::coarse_temp(3'd0)) begin
          res.status = tcc_pkg::ST_RANGE;
        end else begin
          res.result_value = tenc_val;
        end
      end
      tcc_pkg::OP_TAB_DEC: begin
        if (!item.sensor_is_pmic) begin
          res.status = tcc_pkg::ST_SENSOR;
        end else begin
          res.result_value = tdec_val;
        end
      end
      default: begin
        res.status = tcc_pkg::ST_OK;
      end
    endcase
  end

endmodule
